// ----- design/mmcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared types and constants for the min/max contrast stretch block.
// ----------------------------------------------------------------------------
package mmcs_pkg;

	localparam int PIX_W     = 8;
	localparam int NUM_W     = 17;          // 510*d + range, d <= range <= 255
	localparam int REM_W     = PIX_W + 1;   // remainder and divisor width
	localparam int DIV_STEPS = PIX_W;       // one quotient bit per cycle
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [PIX_W-1:0] MID_VAL = 8'd128;

	// tuser codes on the input side
	localparam logic CMD_GATHER  = 1'b0;
	localparam logic CMD_STRETCH = 1'b1;

	// running image statistics
	typedef struct packed {
		logic [PIX_W-1:0] lo;
		logic [PIX_W-1:0] hi;
		logic             any;
	} stats_t;

	// one stretch request handed to the divider
	typedef struct packed {
		logic [PIX_W-1:0] dc;      // pixel - min, clamped to range
		logic [PIX_W-1:0] range;   // max - min
		logic             flat;    // uniform or empty image
		logic             last;
	} div_req_t;

	// divider result and status
	typedef struct packed {
		logic             busy;
		logic             valid;
		logic [PIX_W-1:0] pixel;
		logic             last;
	} div_rsp_t;

endpackage
`default_nettype wire

// ----- design/min_max_contrast_stretch.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_max_contrast_stretch
// Two-pass linear contrast stretch of an 8-bit grey image.
// ----------------------------------------------------------------------------
// Stream the image twice: first with tuser = 0 to gather min and max (no
// output), then with tuser = 1 to get one stretched pixel per input pixel,
// round((p-min)*255/(max-min)) with halves rounded up, or 128 for a uniform
// or empty image. tlast on a stretch pixel clears the statistics. Gather
// items never hold tready low. A stretch item holds tready low after its
// acceptance while the block forms the numerator, runs the bit-serial
// divider (one quotient bit per step) and hands the result off into the
// output register; the next item is taken once tready is high again. A
// result that cannot be handed off because the previous one still waits on
// the master side keeps tready low for the length of that stall. The output
// register lets the divider start the next item while a result still waits
// on the master side.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [7:0] s_axis_tdata,   // [7:0] pixel
	input  wire        s_axis_tuser,   // [0] cmd
	input  wire        s_axis_tlast,
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] pixel_out
	output logic       m_axis_tlast
);

	mmcs_pkg::stats_t   stats;
	mmcs_pkg::div_req_t req;
	mmcs_pkg::div_rsp_t rsp;

	logic                       s_acc;
	logic                       gather;
	logic                       stretch;
	logic [mmcs_pkg::PIX_W-1:0] range;
	logic [mmcs_pkg::PIX_W-1:0] diff;
	logic                       out_free;
	logic                       take;

	assign s_axis_tready = !rsp.busy;
	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign gather  = s_acc && (s_axis_tuser == mmcs_pkg::CMD_GATHER);
	assign stretch = s_acc && (s_axis_tuser == mmcs_pkg::CMD_STRETCH);

	mmcs_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (gather),
		.clr    (stretch && s_axis_tlast),
		.pixel  (s_axis_tdata),
		.stats  (stats)
	);

	// offset from min, clamped to the range so the quotient stays in 8 bits
	assign range = stats.hi - stats.lo;
	assign diff  = (s_axis_tdata > stats.lo) ? (s_axis_tdata - stats.lo) : '0;

	always_comb begin
		req.range = range;
		req.dc    = (diff > range) ? range : diff;
		req.flat  = !stats.any || (stats.hi <= stats.lo);
		req.last  = s_axis_tlast;
	end

	mmcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (stretch),
		.req    (req),
		.take   (take),
		.rsp    (rsp)
	);

	// output register
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign take     = rsp.valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (out_free)
			m_axis_tvalid <= rsp.valid;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_axis_tdata <= rsp.pixel;
			m_axis_tlast <= rsp.last;
		end
	end

endmodule
`default_nettype wire

// ----- design/mmcs_stats.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_stats
// Tracks the smallest and largest gathered pixel of the current image.
// ----------------------------------------------------------------------------
module mmcs_stats (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       upd,     // gather item accepted
	input  wire                       clr,     // stretch item with last accepted
	input  wire [mmcs_pkg::PIX_W-1:0] pixel,
	output mmcs_pkg::stats_t          stats
);

	mmcs_pkg::stats_t stats_q;

	// min/max update, cleared at the end of a stretch pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_q.lo  <= '1;
			stats_q.hi  <= '0;
			stats_q.any <= 1'b0;
		end else if (clr) begin
			stats_q.lo  <= '1;
			stats_q.hi  <= '0;
			stats_q.any <= 1'b0;
		end else if (upd) begin
			stats_q.any <= 1'b1;
			if (!stats_q.any) begin
				stats_q.lo <= pixel;
				stats_q.hi <= pixel;
			end else begin
				if (pixel < stats_q.lo)
					stats_q.lo <= pixel;
				if (pixel > stats_q.hi)
					stats_q.hi <= pixel;
			end
		end
	end

	assign stats = stats_q;

endmodule
`default_nettype wire

// ----- design/mmcs_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_div
// Bit-serial restoring divider: floor((510*dc + range) / (2*range)),
// one quotient bit per cycle, result held until taken.
// ----------------------------------------------------------------------------
module mmcs_div (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	input  wire mmcs_pkg::div_req_t req,
	input  wire                    take,
	output mmcs_pkg::div_rsp_t     rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                    state_q;
	logic [mmcs_pkg::CNT_W-1:0]    cnt_q;
	mmcs_pkg::div_req_t            req_q;
	logic [mmcs_pkg::REM_W-1:0]    rem_q;   // partial remainder
	logic [mmcs_pkg::PIX_W-1:0]    nq_q;    // numerator low bits in, quotient out

	logic [mmcs_pkg::NUM_W-1:0]    num;
	logic [mmcs_pkg::REM_W-1:0]    dvs;
	logic [mmcs_pkg::REM_W:0]      shifted;
	logic [mmcs_pkg::REM_W:0]      trial;
	logic                          qbit;

	// numerator 510*dc + range as (dc<<9) - (dc<<1) + range
	assign num = {req_q.dc, 9'b0} - {8'b0, req_q.dc, 1'b0} + {9'b0, req_q.range};
	assign dvs = {req_q.range, 1'b0};

	// one restoring step
	assign shifted = {rem_q, nq_q[mmcs_pkg::PIX_W-1]};
	assign trial   = shifted - {1'b0, dvs};
	assign qbit    = !trial[mmcs_pkg::REM_W];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_RUN;
					cnt_q   <= '0;
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == mmcs_pkg::CNT_W'(mmcs_pkg::DIV_STEPS - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start)
			req_q <= req;
		if (state_q == ST_LOAD) begin
			rem_q <= num[mmcs_pkg::NUM_W-1:mmcs_pkg::PIX_W];
			nq_q  <= num[mmcs_pkg::PIX_W-1:0];
		end else if (state_q == ST_RUN) begin
			rem_q <= qbit ? trial[mmcs_pkg::REM_W-1:0] : shifted[mmcs_pkg::REM_W-1:0];
			nq_q  <= {nq_q[mmcs_pkg::PIX_W-2:0], qbit};
		end
	end

	assign rsp.busy  = (state_q != ST_IDLE);
	assign rsp.valid = (state_q == ST_DONE);
	assign rsp.pixel = req_q.flat ? mmcs_pkg::MID_VAL : nq_q;
	assign rsp.last  = req_q.last;

endmodule
`default_nettype wire

// ----- design/mmcs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcs_checker
// Port-level checks for min_max_contrast_stretch, bound to the top level.
// ----------------------------------------------------------------------------
module mmcs_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_axis_tvalid,
	input wire       s_axis_tready,
	input wire [7:0] s_axis_tdata,
	input wire       s_axis_tuser,
	input wire       s_axis_tlast,
	input wire       m_axis_tvalid,
	input wire       m_axis_tready,
	input wire [7:0] m_axis_tdata,
	input wire       m_axis_tlast
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	// a stretch item occupies the divider
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == mmcs_pkg::CMD_STRETCH)
			|=> !s_axis_tready)
		else $error("ready high right after a stretch item");

	// idle block stays idle without input
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && !s_axis_tvalid |=> s_axis_tready)
		else $error("ready dropped with no item taken");

	// a result only appears after a division held the input side
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("output item without a division in progress");

endmodule

bind min_max_contrast_stretch mmcs_checker u_mmcs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
